// ===== sv/ivt_pkg.sv =====
// Shared types and constants for the indexed vector table.
// No dependencies; used by the channel interfaces and the top level.
package ivt_pkg;

  localparam int DEPTH_DEFAULT     = 64;
  localparam int WORD_BITS_DEFAULT = 32;
  localparam int WORD_BITS_MAX     = 64;

  localparam int CMD_BITS    = 3;
  localparam int POS_BITS    = 8;
  localparam int VALUE_BITS  = 32;
  localparam int DATA_BITS   = 32;
  localparam int INDEX_BITS  = 7;
  localparam int STATUS_BITS = 2;
  localparam int COUNT_BITS  = 7;

  // signed width for position math: position plus count plus one, with sign
  localparam int ARITH_BITS = 10;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_APPEND = 3'd0,
    CMD_INSERT = 3'd1,
    CMD_GET    = 3'd2,
    CMD_PUT    = 3'd3,
    CMD_FIND   = 3'd4,
    CMD_REMOVE = 3'd5,
    CMD_CLEAR  = 3'd6,
    CMD_NOP    = 3'd7
  } cmd_t;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

endpackage

// ===== sv/ivt_if.sv =====
// Request and response channel interfaces for the indexed vector table.
// Depends on ivt_pkg.
interface ivt_req_if;
  logic                                valid;
  logic                                ready;
  ivt_pkg::cmd_t                       command;
  logic signed [ivt_pkg::POS_BITS-1:0] position;
  logic [ivt_pkg::VALUE_BITS-1:0]      value;

  modport source (output valid, command, position, value, input ready);
  modport sink   (input valid, command, position, value, output ready);
endinterface

interface ivt_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [ivt_pkg::DATA_BITS-1:0]    data_out;
  logic [ivt_pkg::INDEX_BITS-1:0]   found_index;
  ivt_pkg::status_t                 status;
  logic [ivt_pkg::COUNT_BITS-1:0]   count;

  modport source (output valid, data_out, found_index, status, count, input ready);
  modport sink   (input valid, data_out, found_index, status, count, output ready);
endinterface

// ===== sv/ivt_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module ivt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== sv/indexed_vector_table_top.sv =====
// Indexed vector table top level: control sequencer around one entry RAM.
// Depends on ivt_pkg, ivt_req_if / ivt_rsp_if and ivt_ram.

// A packed table of up to DEPTH words of WORD_BITS bits plus an entry count.
// Each request carries one command (append, insert at, get, put, find,
// remove at, clear, or no-op on code seven) and yields exactly one response.
// A negative position counts from the end. One request is worked at a time;
// the entries live in a single RAM with one write and one registered read
// port, and every walk over the table moves one entry per cycle through it.
// A new request is taken while the previous response still waits in the
// output register. The table needs no clearing pass after reset: only
// entries below the count are ever read.
module indexed_vector_table_top #(
  parameter int DEPTH     = ivt_pkg::DEPTH_DEFAULT,
  parameter int WORD_BITS = ivt_pkg::WORD_BITS_DEFAULT
) (
  input logic      clk,
  input logic      rst,
  ivt_req_if.sink  req,
  ivt_rsp_if.source rsp
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int AW    = ivt_pkg::ARITH_BITS;
  localparam int WMAX  = ivt_pkg::WORD_BITS_MAX;

  localparam logic signed [AW-1:0] DEPTH_A = AW'(DEPTH);
  localparam logic signed [AW-1:0] ONE_A   = AW'(1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_GET,
    S_SHIFT_UP,
    S_PAD,
    S_FIND,
    S_RM_FIRST,
    S_SHIFT_DN,
    S_DONE
  } state_t;

  // sequencer registers
  state_t                    state, state_next;
  logic [CNT_W-1:0]          cnt, cnt_next;
  logic [WORD_BITS-1:0]      word, word_next;     // request value, masked
  logic [IDX_W-1:0]          pos, pos_next;       // resolved target entry
  logic [IDX_W-1:0]          wa, wa_next;         // walk pointer

  // result being assembled
  logic [ivt_pkg::DATA_BITS-1:0] res_data, res_data_next;
  logic [IDX_W-1:0]              res_found, res_found_next;
  ivt_pkg::status_t              res_status, res_status_next;

  // output register
  logic                            out_valid, out_valid_next;
  logic [ivt_pkg::DATA_BITS-1:0]   out_data, out_data_next;
  logic [ivt_pkg::INDEX_BITS-1:0]  out_found, out_found_next;
  ivt_pkg::status_t                out_status, out_status_next;
  logic [ivt_pkg::COUNT_BITS-1:0]  out_count, out_count_next;

  // RAM ports
  logic                 mem_we;
  logic [IDX_W-1:0]     mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;
  logic                 mem_re;
  logic [IDX_W-1:0]     mem_raddr;
  logic [WORD_BITS-1:0] mem_rdata;

  // value masked to the word width, RAM data widened for the result field
  logic [WMAX-1:0]            val_wide;
  logic [WORD_BITS-1:0]       word_in;
  logic [WMAX-1:0]            rdata_wide;
  logic [ivt_pkg::DATA_BITS-1:0] rdata_out;

  // position resolution
  logic signed [AW-1:0] pos_s;
  logic signed [AW-1:0] cnt_a;
  logic signed [AW-1:0] ex_p;
  logic                 ex_ok;
  logic signed [AW-1:0] ins_raw;
  logic signed [AW-1:0] ins_p;
  logic signed [AW-1:0] put_raw;
  logic signed [AW-1:0] put_p;
  logic                 full;

  ivt_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (DEPTH),
    .AW    (IDX_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  assign val_wide   = WMAX'(req.value);
  assign word_in    = val_wide[WORD_BITS-1:0];
  assign rdata_wide = WMAX'(mem_rdata);
  assign rdata_out  = rdata_wide[ivt_pkg::DATA_BITS-1:0];

  assign pos_s = $signed({{(AW - ivt_pkg::POS_BITS){req.position[ivt_pkg::POS_BITS-1]}},
                          req.position});
  assign cnt_a = $signed(AW'(cnt));
  assign full  = (cnt_a >= DEPTH_A);

  // get / remove: negative counts from the end, must land inside the table
  assign ex_p  = pos_s[AW-1] ? (pos_s + cnt_a) : pos_s;
  assign ex_ok = !ex_p[AW-1] && (ex_p < cnt_a);

  // insert: negative counts from one past the end, clamped to 0..count
  assign ins_raw = pos_s[AW-1] ? (pos_s + cnt_a + ONE_A) : pos_s;
  always_comb begin
    if (ins_raw[AW-1]) begin
      ins_p = '0;
    end else if (ins_raw > cnt_a) begin
      ins_p = cnt_a;
    end else begin
      ins_p = ins_raw;
    end
  end

  // put: negative counts from the end, floor at zero
  assign put_raw = pos_s[AW-1] ? (pos_s + cnt_a) : pos_s;
  assign put_p   = put_raw[AW-1] ? '0 : put_raw;

  assign req.ready       = (state == S_IDLE);
  assign rsp.valid       = out_valid;
  assign rsp.data_out    = out_data;
  assign rsp.found_index = out_found;
  assign rsp.status      = out_status;
  assign rsp.count       = out_count;

  always_comb begin
    state_next      = state;
    cnt_next        = cnt;
    word_next       = word;
    pos_next        = pos;
    wa_next         = wa;
    res_data_next   = res_data;
    res_found_next  = res_found;
    res_status_next = res_status;
    out_valid_next  = out_valid;
    out_data_next   = out_data;
    out_found_next  = out_found;
    out_status_next = out_status;
    out_count_next  = out_count;

    mem_we    = 1'b0;
    mem_waddr = wa;
    mem_wdata = word;
    mem_re    = 1'b0;
    mem_raddr = wa;

    if (out_valid && rsp.ready) begin
      out_valid_next = 1'b0;
    end

    case (state)
      S_IDLE: begin
        if (req.valid) begin
          word_next       = word_in;
          res_data_next   = '0;
          res_found_next  = '0;
          res_status_next = ivt_pkg::ST_OK;
          state_next      = S_DONE;
          case (req.command)
            ivt_pkg::CMD_APPEND: begin
              if (full) begin
                res_status_next = ivt_pkg::ST_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = IDX_W'(cnt);
                mem_wdata = word_in;
                cnt_next  = cnt + 1'b1;
              end
            end
            ivt_pkg::CMD_INSERT: begin
              if (full) begin
                res_status_next = ivt_pkg::ST_FULL;
              end else begin
                // shift entries above the slot up, walking down from the end
                pos_next   = IDX_W'(ins_p);
                wa_next    = IDX_W'(cnt);
                state_next = S_SHIFT_UP;
                if (cnt_a > ins_p) begin
                  mem_re    = 1'b1;
                  mem_raddr = IDX_W'(cnt - 1'b1);
                end
              end
            end
            ivt_pkg::CMD_GET: begin
              if (!ex_ok) begin
                res_status_next = ivt_pkg::ST_INVALID;
              end else begin
                mem_re     = 1'b1;
                mem_raddr  = IDX_W'(ex_p);
                state_next = S_GET;
              end
            end
            ivt_pkg::CMD_PUT: begin
              if (put_p < cnt_a) begin
                mem_we    = 1'b1;
                mem_waddr = IDX_W'(put_p);
                mem_wdata = word_in;
              end else if (put_p >= DEPTH_A) begin
                res_status_next = ivt_pkg::ST_FULL;
              end else begin
                // zero-fill from count up to the target, then store
                pos_next   = IDX_W'(put_p);
                wa_next    = IDX_W'(cnt);
                state_next = S_PAD;
              end
            end
            ivt_pkg::CMD_FIND: begin
              res_status_next = ivt_pkg::ST_INVALID;
              if (cnt != '0) begin
                mem_re     = 1'b1;
                mem_raddr  = '0;
                wa_next    = '0;
                state_next = S_FIND;
              end
            end
            ivt_pkg::CMD_REMOVE: begin
              if (!ex_ok) begin
                res_status_next = ivt_pkg::ST_INVALID;
              end else begin
                mem_re     = 1'b1;
                mem_raddr  = IDX_W'(ex_p);
                wa_next    = IDX_W'(ex_p);
                state_next = S_RM_FIRST;
              end
            end
            ivt_pkg::CMD_CLEAR: begin
              cnt_next = '0;
            end
            default: begin
            end
          endcase
        end
      end

      S_GET: begin
        res_data_next = rdata_out;
        state_next    = S_DONE;
      end

      S_SHIFT_UP: begin
        mem_we = 1'b1;
        if (wa == pos) begin
          mem_waddr  = pos;
          mem_wdata  = word;
          cnt_next   = cnt + 1'b1;
          state_next = S_DONE;
        end else begin
          mem_waddr = wa;
          mem_wdata = mem_rdata;
          wa_next   = wa - 1'b1;
          if ((wa - 1'b1) > pos) begin
            mem_re    = 1'b1;
            mem_raddr = IDX_W'(wa - 2'd2);
          end
        end
      end

      S_PAD: begin
        mem_we = 1'b1;
        if (wa == pos) begin
          mem_waddr  = pos;
          mem_wdata  = word;
          cnt_next   = CNT_W'(pos) + 1'b1;
          state_next = S_DONE;
        end else begin
          mem_waddr = wa;
          mem_wdata = '0;
          wa_next   = wa + 1'b1;
        end
      end

      S_FIND: begin
        if (mem_rdata == word) begin
          res_found_next  = wa;
          res_status_next = ivt_pkg::ST_OK;
          state_next      = S_DONE;
        end else if ((CNT_W'(wa) + 1'b1) == cnt) begin
          state_next = S_DONE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = wa + 1'b1;
          wa_next   = wa + 1'b1;
        end
      end

      S_RM_FIRST: begin
        res_data_next = rdata_out;
        if ((CNT_W'(wa) + 1'b1) < cnt) begin
          mem_re     = 1'b1;
          mem_raddr  = wa + 1'b1;
          state_next = S_SHIFT_DN;
        end else begin
          cnt_next   = cnt - 1'b1;
          state_next = S_DONE;
        end
      end

      S_SHIFT_DN: begin
        // rdata holds entry wa+1, moved down into wa
        mem_we    = 1'b1;
        mem_waddr = wa;
        mem_wdata = mem_rdata;
        if (((CNT_W + 1)'(wa) + 2'd2) < (CNT_W + 1)'(cnt)) begin
          mem_re    = 1'b1;
          mem_raddr = IDX_W'(wa + 2'd2);
          wa_next   = wa + 1'b1;
        end else begin
          cnt_next   = cnt - 1'b1;
          state_next = S_DONE;
        end
      end

      S_DONE: begin
        // hand off once the response register is free or being drained
        if (!out_valid || rsp.ready) begin
          out_valid_next  = 1'b1;
          out_data_next   = res_data;
          out_found_next  = ivt_pkg::INDEX_BITS'(res_found);
          out_status_next = res_status;
          out_count_next  = ivt_pkg::COUNT_BITS'(cnt);
          state_next      = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
    word       <= word_next;
    pos        <= pos_next;
    wa         <= wa_next;
    res_data   <= res_data_next;
    res_found  <= res_found_next;
    res_status <= res_status_next;
    out_data   <= out_data_next;
    out_found  <= out_found_next;
    out_status <= out_status_next;
    out_count  <= out_count_next;
  end

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for indexed_vector_table_top.
// Depends on ivt_pkg, ivt_req_if / ivt_rsp_if and the table RTL; reads no files.
// Requests go in through directed and random tests; an in-bench table model predicts responses.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ivt_pkg::*;

  localparam int TBL_DEPTH  = DEPTH_DEFAULT;
  localparam int DRAIN_WAIT = TBL_DEPTH + 6;  // worst walk through the RAM plus slack
  localparam int HOLD_LEN   = 300;            // long receiver hold-off, in cycles
  localparam int MAX_REPORTS = 10;

  // One request as it goes onto the channel.
  typedef struct packed {
    cmd_t                        command;
    logic signed [POS_BITS-1:0]  position;
    logic [VALUE_BITS-1:0]       value;
  } table_request_t;

  // One response as the table should produce it.
  typedef struct packed {
    logic [DATA_BITS-1:0]   data_out;
    logic [INDEX_BITS-1:0]  found_index;
    status_t                status;
    logic [COUNT_BITS-1:0]  count;
  } table_result_t;

  logic clk;
  logic rst;

  ivt_req_if req_ch ();
  ivt_rsp_if rsp_ch ();

  indexed_vector_table_top uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // Shadow copy of the table, advanced at each accepted request.
  logic [VALUE_BITS-1:0] tbl_entries [TBL_DEPTH];
  int                    tbl_count;

  table_result_t pending_results [$];
  int            mismatches;

  // Idle rates (percent of cycles) and the receiver hold-off counter.
  int send_idle_pct;
  int recv_idle_pct;
  int hold_cycles;
  int fill_target;  // count that the random traffic steers toward

  // 10 ns clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs; well above the slowest legal run.
  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // Receiver: ready changes on the falling edge. A pending hold-off wins over
  // the random stall pattern and is counted down here, one per cycle.
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        rsp_ch.ready <= 1'b0;
        hold_cycles--;
      end else begin
        rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Table model: applies one command to the shadow table and returns the
  // response it implies. Negative positions count back from the end.
  function automatic table_result_t apply_table_command(table_request_t rq);
    table_result_t res;
    int            idx;
    int            i;
    res        = '0;
    res.status = ST_OK;
    idx        = int'(rq.position);  // sign-extends
    case (rq.command)
      CMD_APPEND: begin
        if (tbl_count >= TBL_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          tbl_entries[tbl_count] = rq.value;
          tbl_count++;
        end
      end
      CMD_INSERT: begin
        // insert clamps the position into 0..count
        if (idx < 0) idx += tbl_count + 1;
        if (idx < 0) idx = 0;
        if (idx > tbl_count) idx = tbl_count;
        if (tbl_count >= TBL_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          for (i = tbl_count; i > idx; i--) tbl_entries[i] = tbl_entries[i-1];
          tbl_entries[idx] = rq.value;
          tbl_count++;
        end
      end
      CMD_GET, CMD_REMOVE: begin
        if (idx < 0) idx += tbl_count;
        if (idx < 0 || idx >= tbl_count) begin
          res.status = ST_INVALID;
        end else begin
          res.data_out = tbl_entries[idx];
          if (rq.command == CMD_REMOVE) begin
            for (i = idx; i + 1 < tbl_count; i++) tbl_entries[i] = tbl_entries[i+1];
            tbl_count--;
          end
        end
      end
      CMD_PUT: begin
        // overwrite, or pad the gap with zeros and grow; past capacity is rejected
        if (idx < 0) idx += tbl_count;
        if (idx < 0) idx = 0;
        if (idx < tbl_count) begin
          tbl_entries[idx] = rq.value;
        end else if (idx >= TBL_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          for (i = tbl_count; i < idx; i++) tbl_entries[i] = '0;
          tbl_entries[idx] = rq.value;
          tbl_count = idx + 1;
        end
      end
      CMD_FIND: begin
        res.status = ST_INVALID;
        for (i = 0; i < tbl_count; i++) begin
          if (res.status == ST_INVALID && tbl_entries[i] == rq.value) begin
            res.found_index = i[INDEX_BITS-1:0];
            res.status      = ST_OK;
          end
        end
      end
      CMD_CLEAR: tbl_count = 0;
      default: ;  // no-op
    endcase
    res.count = tbl_count[COUNT_BITS-1:0];
    return res;
  endfunction

  task automatic note_mismatch(string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("[%0t] mismatch:%s", $realtime, msg);
  endtask

  // Response checker: every accepted response against the oldest prediction.
  always @(posedge clk) begin : check_responses
    table_result_t want;
    string         diffs;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_results.size() == 0) begin
        note_mismatch(" response with no request outstanding");
      end else begin
        want  = pending_results.pop_front();
        diffs = "";
        if (rsp_ch.data_out !== want.data_out)
          diffs = {diffs, $sformatf(" data_out exp %h got %h", want.data_out, rsp_ch.data_out)};
        if (rsp_ch.found_index !== want.found_index)
          diffs = {diffs, $sformatf(" found_index exp %0d got %0d",
                                    want.found_index, rsp_ch.found_index)};
        if (rsp_ch.status !== want.status)
          diffs = {diffs, $sformatf(" status exp %0d got %0d", want.status, rsp_ch.status)};
        if (rsp_ch.count !== want.count)
          diffs = {diffs, $sformatf(" count exp %0d got %0d", want.count, rsp_ch.count)};
        if (diffs != "") note_mismatch(diffs);
      end
    end
  end

  // Sender: called and returning at a falling edge. Valid is never lowered
  // here after acceptance, so back-to-back requests keep it high; the next
  // call or a pause decides its value, once per step.
  task automatic issue_request(table_request_t rq);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.command  <= rq.command;
    req_ch.position <= rq.position;
    req_ch.value    <= rq.value;
    do @(posedge clk); while (!req_ch.ready);
    pending_results.push_back(apply_table_command(rq));
    @(negedge clk);
  endtask

  task automatic issue(cmd_t c, int p, logic [VALUE_BITS-1:0] v);
    table_request_t rq;
    rq.command  = c;
    rq.position = p[POS_BITS-1:0];
    rq.value    = v;
    issue_request(rq);
  endtask

  // Sender pause until every outstanding response has been seen.
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    wait (pending_results.size() == 0);
    @(negedge clk);
  endtask

  // Random request, steered toward fill_target so the count sweeps the whole
  // range, empty and full included.
  function automatic table_request_t random_request();
    table_request_t rq;
    int             roll;
    int             p;
    int             sh;
    bit             grow;
    grow = (tbl_count <= fill_target);
    roll = $urandom_range(0, 99);
    if (grow) begin
      if      (roll < 30) rq.command = CMD_APPEND;
      else if (roll < 48) rq.command = CMD_INSERT;
      else if (roll < 56) rq.command = CMD_PUT;
      else if (roll < 68) rq.command = CMD_GET;
      else if (roll < 80) rq.command = CMD_FIND;
      else if (roll < 95) rq.command = CMD_REMOVE;
      else if (roll < 97) rq.command = CMD_CLEAR;
      else                rq.command = CMD_NOP;
    end else begin
      if      (roll < 8)  rq.command = CMD_APPEND;
      else if (roll < 16) rq.command = CMD_INSERT;
      else if (roll < 22) rq.command = CMD_PUT;
      else if (roll < 36) rq.command = CMD_GET;
      else if (roll < 50) rq.command = CMD_FIND;
      else if (roll < 95) rq.command = CMD_REMOVE;
      else if (roll < 97) rq.command = CMD_CLEAR;
      else                rq.command = CMD_NOP;
    end

    // position: mostly in the live range, from either end
    roll = $urandom_range(0, 9);
    if (roll < 7) begin
      if (rq.command == CMD_PUT && $urandom_range(0, 3) == 0) begin
        p = tbl_count + $urandom_range(0, 4);  // short zero-padded gap
      end else begin
        p = $urandom_range(0, tbl_count);
        if ($urandom_range(0, 1)) p = -(p + 1);
      end
    end else if (roll == 7) begin
      case ($urandom_range(0, 3))
        0: p = -128;
        1: p = 127;
        2: p = 0;
        default: p = -1;
      endcase
    end else begin
      p = $urandom_range(0, 255) - 128;
    end
    rq.position = p[POS_BITS-1:0];

    // value: finds mostly hit a live entry; small values make duplicates
    roll = $urandom_range(0, 9);
    sh   = $urandom_range(0, VALUE_BITS - 1);
    if (rq.command == CMD_FIND && tbl_count > 0 && roll < 7)
      rq.value = tbl_entries[$urandom_range(0, tbl_count - 1)];
    else if (roll < 4) rq.value = $urandom;
    else if (roll < 7) rq.value = $urandom_range(0, 7);
    else if (roll == 7) rq.value = $urandom_range(0, 1) ? '0 : '1;
    else if (roll == 8) rq.value = VALUE_BITS'(1) << sh;
    else               rq.value = ~(VALUE_BITS'(1) << sh);
    return rq;
  endfunction

  // --- tests ---

  // Every read-type command on an empty table, plus the code-seven no-op.
  task automatic test_empty_table();
    issue(CMD_GET, 0, 32'h0);
    issue(CMD_REMOVE, -1, 32'h0);
    issue(CMD_FIND, 0, 32'h0);
    issue(CMD_NOP, 0, 32'hFFFF_FFFF);
  endtask

  // Position extremes, insert clamping, zero padding, negative indexing.
  task automatic test_edit_ops();
    issue(CMD_APPEND, 0, 32'h0000_0000);
    issue(CMD_APPEND, 0, 32'hFFFF_FFFF);
    issue(CMD_INSERT, -128, 32'hA5A5_0001);  // clamps to the front
    issue(CMD_INSERT, 127, 32'h5A5A_0002);   // clamps to the end
    issue(CMD_INSERT, -1, 32'h1234_5678);    // -1 means past the last entry
    issue(CMD_GET, -1, 32'h0);
    issue(CMD_GET, -128, 32'h0);             // invalid
    issue(CMD_GET, 127, 32'h0);              // invalid
    issue(CMD_PUT, 7, 32'hDEAD_BEEF);        // pads a gap with zeros
    issue(CMD_PUT, -1, 32'hCAFE_F00D);       // overwrite last
    issue(CMD_PUT, -128, 32'h8000_0001);     // saturates to entry zero
    issue(CMD_FIND, 0, 32'hFFFF_FFFF);
    issue(CMD_FIND, 0, 32'h7777_7777);       // no match
    issue(CMD_REMOVE, 127, 32'h0);           // invalid
    issue(CMD_REMOVE, -1, 32'h0);
    issue(CMD_REMOVE, 0, 32'h0);
    issue(CMD_CLEAR, 0, 32'h0);
  endtask

  // Fill to capacity in one padded put, then every rejection when full.
  task automatic test_capacity();
    issue(CMD_PUT, TBL_DEPTH - 1, 32'h0BAD_CAFE);
    issue(CMD_APPEND, 0, 32'h1);
    issue(CMD_INSERT, 0, 32'h2);
    issue(CMD_PUT, TBL_DEPTH, 32'h3);
    issue(CMD_CLEAR, 0, 32'h0);
  endtask

  task automatic test_random_traffic(int n_items);
    int k;
    for (k = 0; k < n_items; k++) begin
      if (k % 40 == 0)
        fill_target = ($urandom_range(0, 3) == 0) ? TBL_DEPTH : $urandom_range(0, TBL_DEPTH);
      issue_request(random_request());
    end
  endtask

  // Receiver holds off for a long stretch while requests keep coming, so the
  // block backs up and stalls its request side.
  task automatic test_output_backpressure();
    hold_cycles = HOLD_LEN;
    test_random_traffic(16);
    wait_drained();
  endtask

  // Sender stops mid-stream until every response is back, then resumes.
  task automatic test_pause_until_drained();
    test_random_traffic(10);
    wait_drained();
    test_random_traffic(10);
  endtask

  initial begin
    rst             = 1'b1;
    req_ch.valid    = 1'b0;
    req_ch.command  = CMD_NOP;
    req_ch.position = '0;
    req_ch.value    = '0;
    tbl_count       = 0;
    mismatches      = 0;
    hold_cycles     = 0;
    fill_target     = TBL_DEPTH / 2;
    send_idle_pct   = 11;
    recv_idle_pct   = 47;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // phase 1: sender mostly busy, receiver stalls often
    test_empty_table();
    test_edit_ops();
    test_capacity();
    test_random_traffic(320);

    // phase 2: roles swapped
    send_idle_pct = 47;
    recv_idle_pct = 11;
    test_random_traffic(320);

    // phase 3: no idling, plus the pressure cases
    wait_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_output_backpressure();
    test_pause_until_drained();
    test_random_traffic(290);

    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== indexed_vector_table_top.f =====
sv/ivt_pkg.sv
sv/ivt_if.sv
sv/ivt_ram.sv
sv/indexed_vector_table_top.sv
dv/testbench.sv
